FILE: sv/floored_budget_admission_unit_defines.svh
// Assertion macros for the floored budget admission unit.
// Expects i_clk and i_rst_n in the scope where the macros are used.
`ifndef FLOORED_BUDGET_ADMISSION_UNIT_DEFINES_SVH
`define FLOORED_BUDGET_ADMISSION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/fba_pkg.sv
// Shared types and constants of the floored budget admission unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package fba_pkg;

    localparam int CNT_W            = 31;
    localparam int BYTES_W          = 32;
    localparam int NUM_ACCOUNTS_DEF = 16;

    localparam logic [CNT_W-1:0] GLOBAL_LIMIT_RST = 31'd1073741824;
    localparam logic [CNT_W-1:0] OWNER_LIMIT_RST  = 31'd536870912;
    localparam logic [CNT_W-1:0] DOMAIN_LIMIT_RST = 31'd805306368;

    // configuration register indexes; byte address is four times the index
    localparam logic [1:0] REG_GLOBAL = 2'd0;
    localparam logic [1:0] REG_OWNER  = 2'd1;
    localparam logic [1:0] REG_DOMAIN = 2'd2;

    // purpose codes; the first three double as class codes
    localparam logic [1:0] P_SOURCE  = 2'd0;
    localparam logic [1:0] P_STAGING = 2'd1;
    localparam logic [1:0] P_OUTPUT  = 2'd2;
    localparam logic [1:0] P_META    = 2'd3;

    localparam logic FN_RESERVE = 1'b0;
    localparam logic FN_FREE    = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_REFUSED   = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // one account row: usage of the four purposes
    typedef logic [3:0][CNT_W-1:0] t_row;

    typedef struct packed {
        logic               func;
        logic [1:0]         mem_class;
        logic               is_metadata;
        logic [BYTES_W-1:0] bytes;
        logic               scoped;
        logic               has_owner;
        logic [3:0]         owner_slot;
        logic [3:0]         domain_slot;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] source_used;
        logic [CNT_W-1:0] staging_used;
        logic [CNT_W-1:0] output_used;
        logic [CNT_W-1:0] metadata_used;
    } t_out_item;

endpackage

`default_nettype wire

FILE: sv/fba_row_mem.sv
// Account row memory: one row of four usage counters per slot.
// Uses fba_pkg; per-row valid bits make unwritten rows read as zero.
`default_nettype none

module fba_row_mem #(
    parameter int  DEPTH = fba_pkg::NUM_ACCOUNTS_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output fba_pkg::t_row      o_rd_row,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire fba_pkg::t_row i_wr_row
);
    import fba_pkg::*;

    t_row             r_mem [DEPTH];
    t_row             r_rd_data;
    logic [DEPTH-1:0] r_valid;
    logic             r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_valid[i_rd_addr];
            end
        end
    end

    // a row never written since reset reads as all zero
    assign o_rd_row = r_rd_ok ? r_rd_data : '0;

endmodule

`default_nettype wire

FILE: sv/fba_level_chk.sv
// Budget check of one level: floors, committed sum and fit compare.
// Uses fba_pkg; three register stages on the usage path: clip, partial sums, total.
`default_nettype none

module fba_level_chk (
    input  wire logic                        i_clk,
    input  wire fba_pkg::t_row               i_used,
    input  wire logic [fba_pkg::CNT_W-1:0]   i_limit,
    input  wire logic [1:0]                  i_purp,
    input  wire logic [fba_pkg::BYTES_W-1:0] i_bytes,
    output logic                             o_fit
);
    import fba_pkg::*;

    function automatic logic [CNT_W-1:0] floor_of(input logic [CNT_W-1:0] lim,
                                                  input logic [1:0] p);
        logic [CNT_W-1:0] f;
        case (p)
            P_SOURCE:  f = lim >> 3;
            P_STAGING: f = lim >> 4;
            P_OUTPUT:  f = lim >> 3;
            default:   f = lim >> 10;
        endcase
        return f;
    endfunction

    t_row             floors;
    t_row             clip;
    logic [CNT_W-1:0] extra;

    t_row             r_clip;
    logic [CNT_W-1:0] r_extra;
    logic [CNT_W:0]   r_sum_lo;
    logic [CNT_W:0]   r_sum_hi;
    logic [CNT_W:0]   r_room;
    logic [CNT_W+1:0] r_total;
    logic [CNT_W:0]   r_room_q;
    logic [CNT_W+2:0] need;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            floors[i] = floor_of(i_limit, 2'(i));
            clip[i]   = (i_used[i] > floors[i]) ? i_used[i] : floors[i];
        end
        // unused part of this purpose's own floor is still available to it
        extra = (floors[i_purp] > i_used[i_purp]) ? floors[i_purp] - i_used[i_purp] : '0;
    end

    always_ff @(posedge i_clk) begin
        r_clip   <= clip;
        r_extra  <= extra;
        r_sum_lo <= {1'b0, r_clip[0]} + {1'b0, r_clip[1]};
        r_sum_hi <= {1'b0, r_clip[2]} + {1'b0, r_clip[3]};
        r_room   <= {1'b0, i_limit} + {1'b0, r_extra};
        r_total  <= {1'b0, r_sum_lo} + {1'b0, r_sum_hi};
        r_room_q <= r_room;
    end

    // fits when bytes + committed <= limit + extra; zero bytes always fit
    assign need  = (CNT_W+3)'(r_total) + (CNT_W+3)'(i_bytes);
    assign o_fit = (i_bytes == '0) || (need <= (CNT_W+3)'(r_room_q));

endmodule

`default_nettype wire

FILE: sv/floored_budget_admission_unit.sv
// Floored budget admission unit: top level, APB limits, sequencer, global counters.
// One transaction at a time: the row read, the three-stage budget check, then the write
// back with the result registered; a new one is taken only in idle, and the decide step
// waits while the output is full and stalled; the output register lets the next start.
// Reset: usage counters and row valid bits clear at once, limits take reset values.
// Depends on fba_pkg, fba_row_mem, fba_level_chk and the assertion macro header.
`default_nettype none

module floored_budget_admission_unit #(
    parameter int NUM_ACCOUNTS = fba_pkg::NUM_ACCOUNTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire fba_pkg::t_in_item i_in,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output fba_pkg::t_out_item o_out,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import fba_pkg::*;

    localparam int AW = (NUM_ACCOUNTS > 1) ? $clog2(NUM_ACCOUNTS) : 1;

    // slot numbers wrap onto the slots present; worked out at elaboration
    function automatic logic [15:0][AW-1:0] build_wrap();
        logic [15:0][AW-1:0] t;
        for (int i = 0; i < 16; i++) begin
            t[i] = AW'(i % NUM_ACCOUNTS);
        end
        return t;
    endfunction

    localparam logic [15:0][AW-1:0] WRAP = build_wrap();

    function automatic logic [CNT_W-1:0] upd(input logic fr,
                                             input logic [CNT_W-1:0] x,
                                             input logic [CNT_W-1:0] d);
        return fr ? x - d : x + d;
    endfunction

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CLIP = 5'b00010,
        S_ADD  = 5'b00100,
        S_SUM  = 5'b01000,
        S_DEC  = 5'b10000
    } t_state;

    // decoded transaction held while it is worked on
    typedef struct packed {
        logic               free;
        logic               meta;
        logic               bad;      // class three without metadata
        logic               scoped;
        logic               owner;    // scoped and names an owner
        logic [1:0]         cls;
        logic [1:0]         purp;
        logic [BYTES_W-1:0] bytes;
        logic [AW-1:0]      oslot;
        logic [AW-1:0]      dslot;
    } t_job;

    t_state           r_state, n_state;
    t_job             r_job, job_in;
    logic [CNT_W-1:0] r_global_limit, r_owner_limit, r_domain_limit;
    logic [CNT_W-1:0] r_src_used, r_stg_used, r_dst_used, r_meta_used;
    logic [CNT_W-1:0] n_src_used, n_stg_used, n_dst_used, n_meta_used;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             in_take, out_take, commit, cfg_wr;
    t_row             g_row, own_row, dom_row, own_wr_row, dom_wr_row;
    logic             g_fit, o_fit, d_fit;
    logic [CNT_W-1:0] cu_sel, lane_o, lane_d, b31;
    logic             refuse, under, apply;
    t_status          status;

    // ---------------------------------------------------------------
    // Configuration: limits written by address, read back the same way
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_global_limit <= GLOBAL_LIMIT_RST;
            r_owner_limit  <= OWNER_LIMIT_RST;
            r_domain_limit <= DOMAIN_LIMIT_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_GLOBAL: r_global_limit <= pwdata[CNT_W-1:0];
                REG_OWNER:  r_owner_limit  <= pwdata[CNT_W-1:0];
                REG_DOMAIN: r_domain_limit <= pwdata[CNT_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_GLOBAL: prdata = {1'b0, r_global_limit};
            REG_OWNER:  prdata = {1'b0, r_owner_limit};
            REG_DOMAIN: prdata = {1'b0, r_domain_limit};
            default:    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Intake: one transaction at a time, decoded on the way in
    // ---------------------------------------------------------------
    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        job_in.free   = i_in.func;
        job_in.meta   = i_in.is_metadata;
        job_in.bad    = !i_in.is_metadata && (i_in.mem_class > P_OUTPUT);
        job_in.scoped = i_in.scoped;
        job_in.owner  = i_in.scoped && i_in.has_owner;
        // metadata is charged inside the staging class
        job_in.cls    = i_in.is_metadata ? P_STAGING : i_in.mem_class;
        job_in.purp   = i_in.is_metadata ? P_META : i_in.mem_class;
        job_in.bytes  = i_in.bytes;
        job_in.oslot  = WRAP[i_in.owner_slot];
        job_in.dslot  = WRAP[i_in.domain_slot];
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_job <= job_in;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: read rows, run the three check stages, decide
    // ---------------------------------------------------------------
    assign out_take = r_out_valid && !i_out_stall;
    // hold the decision until the output register has room
    assign commit   = (r_state == S_DEC) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CLIP;
            S_CLIP:  n_state = S_ADD;
            S_ADD:   n_state = S_SUM;
            S_SUM:   n_state = S_DEC;
            S_DEC:   if (commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------
    // Account rows: read at intake, written back on commit. The next
    // read comes in a later cycle than the write, so no forwarding.
    // ---------------------------------------------------------------
    fba_row_mem #(.DEPTH(NUM_ACCOUNTS)) u_owner_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_take),
        .i_rd_addr (job_in.oslot),
        .o_rd_row  (own_row),
        .i_wr_en   (commit && apply && r_job.owner),
        .i_wr_addr (r_job.oslot),
        .i_wr_row  (own_wr_row)
    );

    fba_row_mem #(.DEPTH(NUM_ACCOUNTS)) u_domain_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_take),
        .i_rd_addr (job_in.dslot),
        .o_rd_row  (dom_row),
        .i_wr_en   (commit && apply && r_job.scoped),
        .i_wr_addr (r_job.dslot),
        .i_wr_row  (dom_wr_row)
    );

    // ---------------------------------------------------------------
    // Budget checks at the three levels, run in parallel
    // ---------------------------------------------------------------
    always_comb begin
        g_row[P_SOURCE]  = r_src_used;
        // staging purpose proper excludes metadata, never below zero
        g_row[P_STAGING] = (r_stg_used >= r_meta_used) ? r_stg_used - r_meta_used : '0;
        g_row[P_OUTPUT]  = r_dst_used;
        g_row[P_META]    = r_meta_used;
    end

    fba_level_chk u_global_chk (
        .i_clk   (i_clk),
        .i_used  (g_row),
        .i_limit (r_global_limit),
        .i_purp  (r_job.purp),
        .i_bytes (r_job.bytes),
        .o_fit   (g_fit)
    );

    fba_level_chk u_owner_chk (
        .i_clk   (i_clk),
        .i_used  (own_row),
        .i_limit (r_owner_limit),
        .i_purp  (r_job.purp),
        .i_bytes (r_job.bytes),
        .o_fit   (o_fit)
    );

    fba_level_chk u_domain_chk (
        .i_clk   (i_clk),
        .i_used  (dom_row),
        .i_limit (r_domain_limit),
        .i_purp  (r_job.purp),
        .i_bytes (r_job.bytes),
        .o_fit   (d_fit)
    );

    // ---------------------------------------------------------------
    // Decision and update
    // ---------------------------------------------------------------
    assign b31    = r_job.bytes[CNT_W-1:0];
    assign lane_o = own_row[r_job.purp];
    assign lane_d = dom_row[r_job.purp];

    always_comb begin
        case (r_job.cls)
            P_SOURCE:  cu_sel = r_src_used;
            P_STAGING: cu_sel = r_stg_used;
            P_OUTPUT:  cu_sel = r_dst_used;
            default:   cu_sel = '0;
        endcase
    end

    always_comb begin
        refuse = !g_fit || (r_job.owner && !o_fit) || (r_job.scoped && !d_fit);

        // a free must be covered by every counter it touches; staging bytes
        // that are not metadata must also be covered net of metadata
        under = ({1'b0, cu_sel} < r_job.bytes)
             || (r_job.meta && ({1'b0, r_meta_used} < r_job.bytes))
             || (!r_job.meta && (r_job.cls == P_STAGING)
                 && ((r_stg_used < r_meta_used)
                     || ({1'b0, r_stg_used - r_meta_used} < r_job.bytes)))
             || (r_job.owner && ({1'b0, lane_o} < r_job.bytes))
             || (r_job.scoped && ({1'b0, lane_d} < r_job.bytes));

        if (r_job.bad) begin
            status = r_job.free ? ST_UNDERFLOW : ST_REFUSED;
        end else if (r_job.free) begin
            status = under ? ST_UNDERFLOW : ST_OK;
        end else begin
            status = refuse ? ST_REFUSED : ST_OK;
        end
        apply = (status == ST_OK);
    end

    always_comb begin
        n_src_used  = r_src_used;
        n_stg_used  = r_stg_used;
        n_dst_used  = r_dst_used;
        n_meta_used = r_meta_used;
        if (apply) begin
            case (r_job.cls)
                P_SOURCE:  n_src_used = upd(r_job.free, r_src_used, b31);
                P_STAGING: n_stg_used = upd(r_job.free, r_stg_used, b31);
                P_OUTPUT:  n_dst_used = upd(r_job.free, r_dst_used, b31);
                default: ;
            endcase
            if (r_job.meta) begin
                n_meta_used = upd(r_job.free, r_meta_used, b31);
            end
        end

        // modify only the lane of this purpose in each row
        own_wr_row             = own_row;
        own_wr_row[r_job.purp] = upd(r_job.free, lane_o, b31);
        dom_wr_row             = dom_row;
        dom_wr_row[r_job.purp] = upd(r_job.free, lane_d, b31);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_used  <= '0;
            r_stg_used  <= '0;
            r_dst_used  <= '0;
            r_meta_used <= '0;
        end else if (commit) begin
            r_src_used  <= n_src_used;
            r_stg_used  <= n_stg_used;
            r_dst_used  <= n_dst_used;
            r_meta_used <= n_meta_used;
        end
    end

    // ---------------------------------------------------------------
    // Output register: holds one result until the consumer takes it
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out.status        <= status;
            r_out.source_used   <= n_src_used;
            r_out.staging_used  <= n_stg_used;
            r_out.output_used   <= n_dst_used;
            r_out.metadata_used <= n_meta_used;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
`include "floored_budget_admission_unit_defines.svh"

    `FBA_ASSERT_NEXT(a_take_starts_check, in_take, r_state == S_CLIP, "accepted transaction did not start the check")
    `FBA_ASSERT_NOW(a_result_from_decide, $rose(r_out_valid), $past(r_state) == S_DEC, "result appeared outside the decide step")
    `FBA_ASSERT_NEXT(a_free_never_grows, commit && r_job.free, r_src_used <= $past(r_src_used), "free transaction grew source usage")

endmodule

`default_nettype wire
